>>> rtl/btmx_pkg.sv
// Package for the binary trie max-xor engine: command and status codes,
// default sizes and the controller state type. No dependencies.
package btmx_pkg;

  localparam int KEY_BITS_DEF = 31;
  localparam int NODES_DEF    = 4096;

  localparam int CMD_W  = 2;
  localparam int VAL_W  = 31;
  localparam int STAT_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_WALK,
    ST_INS_ALLOC,
    ST_INS_LEAF,
    ST_QRY_WALK,
    ST_DONE
  } state_t;

endpackage

>>> rtl/binary_trie_max_xor_top.sv
// Binary trie max-xor engine, top level: controller and trie node store.
// Depends on btmx_pkg and btmx_ram.
//
//  channel | handshake            | word
//  --------+----------------------+---------------------------------------
//  in      | in_valid, in_stall   | in_cmd, in_key_value (receiver: here)
//  out     | out_valid, out_stall | out_max_xor, out_status (sender: here)
//
// Insert: L levels walked (one node read per cycle), then W node writes, one
// per cycle: the parent link plus one per new node, none on a duplicate key or
// a full store. Query: KEY_BITS levels walked. Clear and unused commands walk
// no levels. One word in flight; the node RAM port sets the pace. Reset is
// immediate (root links masked by a valid flag). in_stall is high while a word
// is being worked on; a finished result may wait in the output register while
// the next word is taken.
module binary_trie_max_xor_top #(
  parameter int KEY_BITS = btmx_pkg::KEY_BITS_DEF,
  parameter int NODES    = btmx_pkg::NODES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [btmx_pkg::CMD_W-1:0]    in_cmd,
  input  logic [btmx_pkg::VAL_W-1:0]    in_key_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [btmx_pkg::VAL_W-1:0]    out_max_xor,
  output logic [btmx_pkg::STAT_W-1:0]   out_status
);

  import btmx_pkg::*;

  localparam int NB = $clog2(NODES);
  localparam int EW = 2 * NB;
  localparam int LW = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
  localparam int CW = NB + LW + 2;

  state_t state_r, state_nxt;

  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [KEY_BITS-1:0] ans_r, ans_nxt;
  logic [LW-1:0]       level_r, level_nxt;
  logic [NB-1:0]       x_r, x_nxt;
  logic [NB-1:0]       count_r, count_nxt;
  logic [EW-1:0]       par_r, par_nxt;
  logic                first_r, first_nxt;
  logic                holds_r, holds_nxt;
  logic                root_ok_r, root_ok_nxt;
  logic                rd_root_r;
  logic [STAT_W-1:0]   stat_r, stat_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_max_xor_r, out_max_xor_nxt;
  logic [STAT_W-1:0]   out_status_r, out_status_nxt;

  logic          ram_we;
  logic [NB-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [NB-1:0] ram_raddr;
  logic [EW-1:0] ram_rdata;

  logic [EW-1:0] cur;
  logic          kb;
  logic [NB-1:0] link_k, link_o, nn;
  logic          full;
  logic          in_acc, out_free;

  btmx_ram #(
    .WIDTH(EW),
    .DEPTH(NODES)
  ) u_nodes (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // root entry reads as empty until first written after reset or clear
  assign cur    = (rd_root_r && !root_ok_r) ? '0 : ram_rdata;
  assign kb     = key_r[level_r];
  assign link_k = kb ? cur[EW-1:NB] : cur[NB-1:0];
  assign link_o = kb ? cur[NB-1:0] : cur[EW-1:NB];
  assign nn     = count_r + NB'(1);
  assign full   = (CW'(count_r) + CW'(level_r) + CW'(1)) > CW'(NODES - 1);

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_cmd == CMD_INSERT) state_nxt = ST_INS_WALK;
          else if (in_cmd == CMD_QUERY && holds_r) state_nxt = ST_QRY_WALK;
          else state_nxt = ST_DONE;
        end
      end
      ST_INS_WALK: begin
        if (link_k == '0) state_nxt = full ? ST_DONE : ST_INS_ALLOC;
        else if (level_r == '0) state_nxt = ST_DONE;
      end
      ST_INS_ALLOC: begin
        if (level_r == '0) state_nxt = ST_INS_LEAF;
      end
      ST_INS_LEAF: state_nxt = ST_DONE;
      ST_QRY_WALK: begin
        if (level_r == '0) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    key_nxt       = key_r;
    ans_nxt       = ans_r;
    level_nxt     = level_r;
    x_nxt         = x_r;
    count_nxt     = count_r;
    par_nxt       = par_r;
    first_nxt     = first_r;
    holds_nxt     = holds_r;
    root_ok_nxt   = root_ok_r;
    stat_nxt      = stat_r;
    ram_we        = 1'b0;
    ram_waddr     = x_r;
    ram_wdata     = '0;
    ram_raddr     = '0;
    out_valid_nxt   = out_valid_r && out_stall;
    out_max_xor_nxt = out_max_xor_r;
    out_status_nxt  = out_status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          key_nxt   = KEY_BITS'(in_key_value);
          ans_nxt   = '0;
          level_nxt = LW'(KEY_BITS - 1);
          x_nxt     = '0;
          stat_nxt  = STAT_OK;
          unique case (in_cmd)
            CMD_INSERT: ;
            CMD_QUERY: begin
              if (!holds_r) stat_nxt = STAT_EMPTY;
            end
            CMD_CLEAR: begin
              count_nxt   = '0;
              holds_nxt   = 1'b0;
              root_ok_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_INS_WALK: begin
        if (link_k == '0) begin
          par_nxt   = cur;
          first_nxt = 1'b1;
          if (full) stat_nxt = STAT_FULL;
        end else begin
          x_nxt     = link_k;
          ram_raddr = link_k;
          if (level_r == '0) holds_nxt = 1'b1;
          else level_nxt = level_r - LW'(1);
        end
      end
      ST_INS_ALLOC: begin
        // parent is the branch node (old links kept) or a fresh chain node
        ram_we    = 1'b1;
        ram_waddr = x_r;
        ram_wdata = first_r ? par_r : '0;
        if (kb) ram_wdata[EW-1:NB] = nn;
        else ram_wdata[NB-1:0] = nn;
        if (x_r == '0) root_ok_nxt = 1'b1;
        first_nxt = 1'b0;
        count_nxt = nn;
        x_nxt     = nn;
        if (level_r != '0) level_nxt = level_r - LW'(1);
      end
      ST_INS_LEAF: begin
        ram_we    = 1'b1;
        ram_waddr = x_r;
        ram_wdata = '0;
        holds_nxt = 1'b1;
      end
      ST_QRY_WALK: begin
        if (link_o != '0) begin
          ans_nxt   = (ans_r << 1) | KEY_BITS'(1);
          x_nxt     = link_o;
          ram_raddr = link_o;
        end else begin
          ans_nxt   = ans_r << 1;
          x_nxt     = link_k;
          ram_raddr = link_k;
        end
        if (level_r != '0) level_nxt = level_r - LW'(1);
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_max_xor_nxt = VAL_W'(ans_r);
          out_status_nxt  = stat_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      holds_r     <= 1'b0;
      root_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
      first_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      holds_r     <= holds_nxt;
      root_ok_r   <= root_ok_nxt;
      out_valid_r <= out_valid_nxt;
      first_r     <= first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r         <= key_nxt;
    ans_r         <= ans_nxt;
    level_r       <= level_nxt;
    x_r           <= x_nxt;
    par_r         <= par_nxt;
    stat_r        <= stat_nxt;
    rd_root_r     <= (ram_raddr == '0);
    out_max_xor_r <= out_max_xor_nxt;
    out_status_r  <= out_status_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_max_xor = out_max_xor_r;
  assign out_status  = out_status_r;

endmodule

>>> rtl/btmx_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module btmx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
